// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/mvm_pkg.sv
// package: beat types and register indexes for the matrix-vector multiplier
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

    localparam int DATA_W      = 32;
    localparam int ROW_INDEX_W = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 2'd1;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] NUM_ROWS_RESET = 10'd512;
    localparam logic [CFG_DATA_W-1:0] NUM_COLS_RESET = 10'd512;

    // input item modes
    localparam logic MODE_LOAD_VECTOR = 1'b0;
    localparam logic MODE_MATRIX      = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] value;
    } mvm_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  row_sum;
        logic [ROW_INDEX_W-1:0]    row_index;
        logic                      last_row;
    } mvm_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/matrix_vector_multiply_top.sv
// top level: streaming integer matrix-vector multiplier with on-chip vector memory
`timescale 1ns / 1ps
`default_nettype none

// Integer matrix-vector multiply y = A * x on 32-bit two's complement values.
// Load the vector first with mode 0 beats, one element per beat, in order;
// then stream the matrix row-major with mode 1 beats. Each matrix beat reads
// the vector entry of its column from a single-port-style memory (one write
// or one read per cycle, registered read data), multiplies, and adds into a
// row accumulator; all arithmetic wraps modulo 2^32. After the last column
// of a row one result beat carries the row sum, the row index (low 9 bits of
// the row counter) and a last-row flag. Throughput is one input beat per
// cycle, vector loads and matrix elements alike, unless the input stalls.
// An accepted matrix beat passes the memory read, the multiply register and
// the accumulate into the output register. The input stalls only when a
// new row sum is ready while the previous one still sits unaccepted in the
// output register; the whole pipeline then holds for that cycle. Register
// values of zero act as one and values above MAX_ROWS / MAX_COLS act as the
// maximum. Counters keep their values across register writes and wrap at
// the next row or vector end. Reading a vector entry never written since
// reset returns undefined data. Register writes are always ready and
// should be made while no matrix row is in flight.
module matrix_vector_multiply_top #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // item input
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire mvm_pkg::mvm_in_t               in_data,
    // result output
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output mvm_pkg::mvm_out_t                   out_data,
    // register writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mvm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // counter and count widths
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int COLC_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ROWC_W = $clog2(MAX_ROWS + 1);

    // configuration registers
    logic [mvm_pkg::CFG_DATA_W-1:0] num_rows_reg;
    logic [mvm_pkg::CFG_DATA_W-1:0] num_cols_reg;

    // position counters
    logic [COL_W-1:0] load_pos_reg, load_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;

    // vector memory and its registered read data
    logic [mvm_pkg::DATA_W-1:0] vec_mem [MAX_COLS];
    logic [mvm_pkg::DATA_W-1:0] rd_reg;

    // stage 1: memory read in flight
    logic                       s1_valid_reg;
    logic                       s1_end_reg;
    logic                       s1_last_reg;
    logic [ROW_W-1:0]           s1_row_reg;
    logic [mvm_pkg::DATA_W-1:0] s1_value_reg;

    // stage 2: product ready
    logic                       s2_valid_reg;
    logic                       s2_end_reg;
    logic                       s2_last_reg;
    logic [ROW_W-1:0]           s2_row_reg;
    logic [mvm_pkg::DATA_W-1:0] prod_reg;
    logic [mvm_pkg::DATA_W-1:0] prod_next;

    // accumulator and output register
    logic [mvm_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic [mvm_pkg::DATA_W-1:0] sum_now;
    logic                       out_valid_reg, out_valid_next;
    mvm_pkg::mvm_out_t          out_data_reg;

    // effective counts after clamping
    logic [COLC_W-1:0] cols_eff;
    logic [ROWC_W-1:0] rows_eff;
    logic [COLC_W-1:0] col_inc, load_inc;
    logic [ROWC_W-1:0] row_inc;
    logic              row_end, mat_last, load_end;

    logic advance;
    logic in_fire, load_fire, mat_fire;
    logic emit;

    // the pipeline holds only when a row sum must enter a full, stalled output register
    assign advance   = !(s2_valid_reg && s2_end_reg && out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign in_fire   = in_valid && advance;
    assign load_fire = in_fire && (in_data.mode == mvm_pkg::MODE_LOAD_VECTOR);
    assign mat_fire  = in_fire && (in_data.mode == mvm_pkg::MODE_MATRIX);
    assign emit      = advance && s2_valid_reg && s2_end_reg;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (num_cols_reg == '0)
            cols_eff = COLC_W'(1);
        else if (int'(num_cols_reg) > MAX_COLS)
            cols_eff = COLC_W'(MAX_COLS);
        else
            cols_eff = COLC_W'(num_cols_reg);

        if (num_rows_reg == '0)
            rows_eff = ROWC_W'(1);
        else if (int'(num_rows_reg) > MAX_ROWS)
            rows_eff = ROWC_W'(MAX_ROWS);
        else
            rows_eff = ROWC_W'(num_rows_reg);
    end

    // counter stepping
    always_comb
    begin
        load_inc = COLC_W'(load_pos_reg) + COLC_W'(1);
        col_inc  = COLC_W'(col_pos_reg) + COLC_W'(1);
        row_inc  = ROWC_W'(row_pos_reg) + ROWC_W'(1);
        load_end = load_inc >= cols_eff;
        row_end  = col_inc >= cols_eff;
        mat_last = row_inc >= rows_eff;

        load_pos_next = load_pos_reg;
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;

        if (load_fire)
            load_pos_next = load_end ? '0 : COL_W'(load_inc);

        if (mat_fire)
        begin
            col_pos_next = row_end ? '0 : COL_W'(col_inc);
            if (row_end)
                row_pos_next = mat_last ? '0 : ROW_W'(row_inc);
        end
    end

    // multiply keeps the low 32 bits, which match for signed and unsigned
    assign prod_next = mvm_pkg::DATA_W'(s1_value_reg * rd_reg);
    assign sum_now   = acc_reg + prod_reg;

    // accumulate and output register control
    always_comb
    begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance && s2_valid_reg)
            acc_next = s2_end_reg ? '0 : sum_now;
        if (emit)
            out_valid_next = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= mvm_pkg::NUM_ROWS_RESET;
            num_cols_reg  <= mvm_pkg::NUM_COLS_RESET;
            load_pos_reg  <= '0;
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mvm_pkg::REG_NUM_ROWS)
                    num_rows_reg <= cfg_data;
                else if (cfg_index == mvm_pkg::REG_NUM_COLS)
                    num_cols_reg <= cfg_data;
            end
            load_pos_reg  <= load_pos_next;
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            if (advance)
            begin
                s1_valid_reg <= mat_fire;
                s2_valid_reg <= s1_valid_reg;
            end
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // vector memory: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (load_fire)
            vec_mem[load_pos_reg] <= in_data.value;
        if (mat_fire)
            rd_reg <= vec_mem[col_pos_reg];
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (mat_fire)
        begin
            s1_value_reg <= in_data.value;
            s1_end_reg   <= row_end;
            s1_last_reg  <= mat_last;
            s1_row_reg   <= row_pos_reg;
        end
        if (advance && s1_valid_reg)
        begin
            prod_reg    <= prod_next;
            s2_end_reg  <= s1_end_reg;
            s2_last_reg <= s1_last_reg;
            s2_row_reg  <= s1_row_reg;
        end
        if (emit)
        begin
            out_data_reg.row_sum   <= sum_now;
            out_data_reg.row_index <= mvm_pkg::ROW_INDEX_W'(s2_row_reg);
            out_data_reg.last_row  <= s2_last_reg;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mvm_checker.sv
// checker: port-level assertions for the matrix-vector multiplier, with its bind
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mvm_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire mvm_pkg::mvm_in_t                in_data,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire mvm_pkg::mvm_out_t               out_data,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready,
    input wire logic [mvm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input wire logic [mvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // input backpressure only while a result is waiting on a stalled output
    `ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // register writes never wait
    `ASSERT_SAME(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

    // a stalled result beat stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // a stalled result beat keeps its payload
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

endmodule

bind matrix_vector_multiply_top mvm_checker u_mvm_checker (.*);

`default_nettype wire

// File: bench/matrix_vector_multiply_top_test.sv
// testbench for the streaming integer matrix-vector multiplier
`timescale 1ns / 1ps

module matrix_vector_multiply_top_test;
    import mvm_pkg::*;

    localparam int MAX_COLS = 512;
    localparam int MAX_ROWS = 512;
    // pipeline is three deep; a partial row may still be in flight with no result due
    localparam int SETTLE_CYCLES = 8;
    localparam int GAP_PCT = 13;
    localparam int MAX_PRINTS = 40;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VAL_NEG_ONE = 32'hffff_ffff;

    // matrix shape of the first job of a random run
    typedef enum int {SHAPE_SMALL, SHAPE_TALL, SHAPE_WIDE} shape_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    mvm_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    mvm_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // random idling on both channels
    bit gaps_on = 1'b1;

    // predicted block state
    logic [DATA_W-1:0] x_mem [MAX_COLS];
    bit x_written [MAX_COLS];
    int unsigned load_pos = 0;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    logic [DATA_W-1:0] row_acc = '0;
    logic [CFG_DATA_W-1:0] rows_reg = NUM_ROWS_RESET;
    logic [CFG_DATA_W-1:0] cols_reg = NUM_COLS_RESET;

    // row sums predicted but not yet seen on the output
    mvm_out_t pending_rows [$];

    int unsigned beats_sent = 0;
    int unsigned rows_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;

    matrix_vector_multiply_top #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver backpressure on about 13 percent of cycles while idling is on
    always @(posedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
    end

    // zero acts as one, anything past the maximum acts as the maximum
    function automatic int unsigned clamp_count(input logic [CFG_DATA_W-1:0] raw,
                                                input int unsigned limit);
        if (raw == 0)
            return 1;
        if (raw > limit)
            return limit;
        return raw;
    endfunction

    // extremes now and then, otherwise any 32-bit pattern
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_NEG_ONE;
            3: return '0;
            4: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // one accepted input beat: either store a vector entry or accumulate a
    // matrix element; a completed row queues its expected sum
    function automatic void predict_row_sums(input mvm_in_t beat);
        int unsigned cols;
        int unsigned rows;
        logic [DATA_W-1:0] product;
        mvm_out_t res;
        cols = clamp_count(cols_reg, MAX_COLS);
        rows = clamp_count(rows_reg, MAX_ROWS);
        if (beat.mode == MODE_LOAD_VECTOR)
        begin
            x_mem[load_pos % MAX_COLS] = beat.value;
            x_written[load_pos % MAX_COLS] = 1'b1;
            load_pos++;
            if (load_pos >= cols)
                load_pos = 0;
        end
        else
        begin
            // low 32 bits of the product are the same signed or unsigned
            product = beat.value * x_mem[col_pos % MAX_COLS];
            row_acc = row_acc + product;
            col_pos++;
            // a column counter left past a shrunken width also ends the row here
            if (col_pos >= cols)
            begin
                res.row_sum = row_acc;
                res.row_index = row_pos[ROW_INDEX_W-1:0];
                res.last_row = (row_pos + 1 >= rows);
                pending_rows.push_back(res);
                col_pos = 0;
                row_acc = '0;
                row_pos = res.last_row ? 0 : row_pos + 1;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns mismatch: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // send one input beat; valid stays high from beat to beat unless a gap is drawn
    task automatic send_beat(input logic mode, input logic [DATA_W-1:0] value);
        mvm_in_t beat;
        beat.mode = mode;
        beat.value = value;
        if (gaps_on && $urandom_range(99) < GAP_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_row_sums(beat);
        beats_sent++;
    endtask

    // matrix beat; the vector entry of its column must have been loaded first
    task automatic send_element(input logic [DATA_W-1:0] value);
        while (!x_written[col_pos % MAX_COLS])
            send_beat(MODE_LOAD_VECTOR, pick_value());
        send_beat(MODE_MATRIX, value);
    endtask

    // drop valid, let every expected row sum out, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (index == REG_NUM_ROWS)
            rows_reg = data;
        else if (index == REG_NUM_COLS)
            cols_reg = data;
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_shape(input logic [CFG_DATA_W-1:0] rows_raw,
                             input logic [CFG_DATA_W-1:0] cols_raw);
        wait_idle();
        write_reg(REG_NUM_ROWS, rows_raw);
        write_reg(REG_NUM_COLS, cols_raw);
    endtask

    // 2x2 matrix on the most negative and most positive values, sums wrap
    task automatic test_signed_extremes();
        set_shape(2, 2);
        send_beat(MODE_LOAD_VECTOR, VAL_MIN);
        send_beat(MODE_LOAD_VECTOR, VAL_MAX);
        send_element(VAL_MIN);
        send_element(VAL_MAX);
        send_element(VAL_NEG_ONE);
        send_element(VAL_NEG_ONE);
    endtask

    // unmapped indexes are ignored, zero sizes act as one
    task automatic test_register_limits();
        wait_idle();
        write_reg(REG_SPARE_2, 10'h3ff);
        write_reg(REG_SPARE_3, 10'h155);
        set_shape(0, 0);
        send_beat(MODE_LOAD_VECTOR, VAL_NEG_ONE);
        // 1x1 matrix, so every element is a whole matrix flagged as last row
        send_element(VAL_MAX);
        send_element(VAL_MIN);
    endtask

    // shape shrinks under a half-done row, then a vector entry is rewritten mid-row
    task automatic test_midstream_change();
        set_shape(3, 4);
        repeat (4) send_beat(MODE_LOAD_VECTOR, pick_value());
        // row 0 done, row 1 stopped at column 2
        repeat (6) send_element(pick_value());
        // column 2 is past a width of two, row 1 past a height of one
        set_shape(1, 2);
        send_element(pick_value());
        send_element(pick_value());
        send_beat(MODE_LOAD_VECTOR, pick_value());
        send_element(pick_value());
        // next row picks up the rewritten entry
        repeat (2) send_element(pick_value());
    endtask

    // random shapes, mostly clean matrices against a fresh vector; some jobs
    // reuse the stored vector, stop mid-matrix, or slip vector loads in
    task automatic run_random_jobs(input int unsigned budget, input shape_kind_t first_shape);
        int unsigned stop_at;
        int unsigned n_elems;
        int unsigned shape_pick;
        logic [CFG_DATA_W-1:0] rows_raw;
        logic [CFG_DATA_W-1:0] cols_raw;
        bit noisy;
        shape_kind_t shape;
        stop_at = beats_sent + budget;
        shape = first_shape;
        while (beats_sent < stop_at)
        begin
            shape_pick = $urandom_range(99);
            rows_raw = $urandom_range(6, 0);
            cols_raw = $urandom_range(8, 0);
            if (shape == SHAPE_TALL)
            begin
                // all 512 rows, height register at or past the maximum
                rows_raw = $urandom_range(1023, MAX_ROWS);
                cols_raw = $urandom_range(1, 0);
                shape_pick = 50;
            end
            else if (shape == SHAPE_WIDE)
            begin
                rows_raw = 1;
                cols_raw = $urandom_range(1023, MAX_COLS);
                shape_pick = 50;
            end
            shape = SHAPE_SMALL;
            set_shape(rows_raw, cols_raw);
            if (shape_pick >= 20)
                repeat (clamp_count(cols_raw, MAX_COLS))
                    send_beat(MODE_LOAD_VECTOR, pick_value());
            n_elems = clamp_count(rows_raw, MAX_ROWS) * clamp_count(cols_raw, MAX_COLS);
            if (shape_pick < 10)
                n_elems = $urandom_range(n_elems - 1, 0);
            else if (shape_pick >= 80)
                n_elems = 2 * n_elems;
            noisy = ($urandom_range(99) < 15);
            repeat (n_elems)
            begin
                if (noisy && $urandom_range(5) == 0)
                    send_beat(MODE_LOAD_VECTOR, pick_value());
                send_element(pick_value());
            end
            // next column entry loaded while it is still reachable under this width
            while (!x_written[col_pos % MAX_COLS])
                send_beat(MODE_LOAD_VECTOR, pick_value());
        end
    endtask

    // long back-to-back stretch, includes the full 512-row matrix
    task automatic test_streaming_no_gaps();
        gaps_on = 1'b0;
        run_random_jobs(200, SHAPE_TALL);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    // idling on both sides, includes the full 512-column row
    task automatic test_random_with_gaps();
        run_random_jobs(900, SHAPE_WIDE);
    endtask

    // compare each accepted result beat with the oldest predicted row sum
    always @(posedge clk)
    begin : result_check
        mvm_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rows.size() == 0)
                report_mismatch("result beat with no row pending", out_data.row_sum, '0);
            else
            begin
                want = pending_rows.pop_front();
                if (out_data.row_sum !== want.row_sum)
                    report_mismatch($sformatf("row %0d row_sum", want.row_index),
                                    out_data.row_sum, want.row_sum);
                if (out_data.row_index !== want.row_index)
                    report_mismatch("row_index", out_data.row_index, want.row_index);
                if (out_data.last_row !== want.last_row)
                    report_mismatch($sformatf("row %0d last_row", want.row_index),
                                    out_data.last_row, want.last_row);
                rows_seen++;
            end
        end
    end

    initial
    begin
        // reset held from time zero, released on a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_signed_extremes();
        test_register_limits();
        test_midstream_change();
        test_streaming_no_gaps();
        test_random_with_gaps();

        wait_idle();
        $display("run covered %0d input beats, %0d row sums checked, %0d register writes",
                 beats_sent, rows_seen, reg_writes);
        $display("%s", {"shapes from 1x1 to 512 rows and 512 columns, shape changes mid-row, ",
                        "vector rewrites mid-matrix"});
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("matrix_vector_multiply_top verification clean");
        else
            $display("matrix_vector_multiply_top verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("matrix_vector_multiply_top verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mvm_pkg.sv
hw/rtl/matrix_vector_multiply_top.sv
hw/rtl/mvm_checker.sv
bench/matrix_vector_multiply_top_test.sv
